/* rtl/mfpi_pkg.sv */
// ----------------------------------------------------------------------------
// mfpi_pkg
// shared types and constants of the matched filter peak index block
// ----------------------------------------------------------------------------
package mfpi_pkg;

   localparam logic OP_TAP    = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   localparam int TAPS_W  = 9;
   localparam int OUTS_W  = 13;
   localparam int DATA_W  = 16;
   localparam int POS_W   = 12;
   localparam int ACC_W   = 32;
   localparam int CSR_W   = 13;
   localparam int TIDX_W  = 8;

   localparam logic CSR_NUM_TAPS    = 1'b0;
   localparam logic CSR_NUM_OUTPUTS = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic tap_wr;      // write one template tap
      logic smp_wr;      // shift sample into window, capture it
      logic acc_clr;     // start a new correlation sum
      logic acc_step;    // add one product
      logic finish;      // form correlation, update argmax, load result
   } mfpi_cmd_type;

endpackage

/* rtl/mfpi_datapath.sv */
// ----------------------------------------------------------------------------
// mfpi_datapath
// tap memory, sample window memory, multiply accumulate and argmax
// ----------------------------------------------------------------------------
module mfpi_datapath #(
   parameter int MAX_TAPS = 256,
   parameter int AW       = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mfpi_pkg::mfpi_cmd_type        cmd,
   input  logic [7:0]                    tap_index,
   input  logic signed [15:0]            tap_value,
   input  logic signed [15:0]            sample,
   input  logic [AW-1:0]                 rd_k,       // window offset, 0 is newest
   input  logic [AW:0]                   n_taps,
   input  logic [11:0]                   position,
   input  logic                          done,
   output logic signed [15:0]            corr_value,
   output logic [11:0]                   sync_index
);
   import mfpi_pkg::*;

   logic [DATA_W-1:0] tap_mem [MAX_TAPS];
   logic [DATA_W-1:0] win_mem [2**AW];        // circular, wraps with the slot pointer
   logic [AW-1:0]     head_ff, head_in;       // slot of newest sample
   logic [DATA_W-1:0] tap_rd_ff, win_rd_ff;
   logic              rd_vld_ff;
   logic signed [ACC_W-1:0] prod_ff;
   logic              prod_vld_ff;
   logic [ACC_W-1:0]  acc_ff;
   logic signed [DATA_W-1:0] best_ff;
   logic [POS_W-1:0]  best_pos_ff;
   logic signed [DATA_W-1:0] corr_ff;
   logic [POS_W-1:0]  sync_ff;
   logic [AW-1:0]     tap_addr, win_addr;
   logic [ACC_W-1:0]  acc_fin, acc_sh;
   logic signed [DATA_W-1:0] corr_now;

   assign head_in  = head_ff - AW'(1);
   assign tap_addr = AW'(n_taps - (AW+1)'(1) - {1'b0, rd_k});
   assign win_addr = head_ff + rd_k;

   always_ff @(posedge clock) begin
      if (cmd.tap_wr && (32'(tap_index) < MAX_TAPS))
         tap_mem[AW'(tap_index)] <= tap_value;
      if (cmd.smp_wr)
         win_mem[head_in] <= sample;
      tap_rd_ff <= tap_mem[tap_addr];
      win_rd_ff <= win_mem[win_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0; rd_vld_ff <= 1'b0; prod_vld_ff <= 1'b0;
      end else begin
         if (cmd.smp_wr) head_ff <= head_in;
         rd_vld_ff   <= cmd.acc_step;
         prod_vld_ff <= rd_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= $signed(win_rd_ff) * $signed(tap_rd_ff);
   end

   assign acc_fin  = acc_ff;
   assign acc_sh   = acc_fin >> 15 | {{15{acc_fin[ACC_W-1]}}, 17'b0};
   assign corr_now = acc_sh[DATA_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0; best_ff <= '0; best_pos_ff <= '0;
      end else begin
         if (cmd.acc_clr) acc_ff <= '0;
         else if (prod_vld_ff) acc_ff <= acc_ff + prod_ff;
         if (cmd.finish) begin
            if (done) begin
               best_ff <= '0; best_pos_ff <= '0;
            end else if (position == '0 || corr_now > best_ff) begin
               best_ff <= corr_now; best_pos_ff <= position;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         corr_ff <= corr_now;
         if (!done) sync_ff <= '0;
         else if (position == '0 || corr_now > best_ff) sync_ff <= position;
         else sync_ff <= best_pos_ff;
      end
   end

   assign corr_value = corr_ff;
   assign sync_index = sync_ff;
endmodule

/* rtl/mfpi_ctrl.sv */
// ----------------------------------------------------------------------------
// mfpi_ctrl
// sequencer: accepts items, walks the window, tracks frame counters
// ----------------------------------------------------------------------------
module mfpi_ctrl #(
   parameter int MAX_TAPS    = 256,
   parameter int MAX_OUTPUTS = 4096,
   parameter int AW          = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_op,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   input  logic [8:0]             num_taps,
   input  logic [12:0]            num_outputs,
   output mfpi_pkg::mfpi_cmd_type cmd,
   output logic [AW-1:0]          rd_k,
   output logic [AW:0]            n_taps,
   output logic [11:0]            position,
   output logic                   done,
   output logic [11:0]            rsp_position,
   output logic                   rsp_done
);
   import mfpi_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0, S_RUN = 3'd1, S_DRAIN = 3'd2,
                          S_FIN = 3'd3, S_OUT = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [AW:0]   fill_ff, fill_in;
   logic [AW:0]   k_ff, k_in;
   logic [1:0]    drain_ff;
   logic [11:0]   pos_ff;
   logic [11:0]   rpos_ff;
   logic          rdone_ff;
   logic [AW:0]   n_sat;
   logic [12:0]   nout_sat;
   logic          acc_smp;

   always_comb begin
      if (num_taps < 9'd4) n_sat = (AW+1)'(4);
      else if ({23'b0, num_taps} > MAX_TAPS) n_sat = (AW+1)'(MAX_TAPS);
      else n_sat = (AW+1)'(num_taps);
      if (num_outputs == '0) nout_sat = 13'd1;
      else if ({19'b0, num_outputs} > MAX_OUTPUTS) nout_sat = 13'(MAX_OUTPUTS);
      else nout_sat = num_outputs;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign acc_smp   = req_valid && req_ready && (req_op == OP_SAMPLE);
   assign fill_in   = (fill_ff < (AW+1)'(MAX_TAPS)) ? fill_ff + 1'b1 : fill_ff;
   assign k_in      = k_ff + 1'b1;
   assign n_taps    = n_sat;
   assign rd_k      = k_ff[AW-1:0];
   assign position  = pos_ff;
   assign done      = ({1'b0, pos_ff} + 13'd1) >= nout_sat;
   assign rsp_position = rpos_ff;
   assign rsp_done     = rdone_ff;

   always_comb begin
      cmd = '0;
      cmd.tap_wr  = req_valid && req_ready && (req_op == OP_TAP);
      cmd.smp_wr  = acc_smp;
      cmd.acc_clr = acc_smp;
      cmd.acc_step = (state_ff == S_RUN);
      cmd.finish  = (state_ff == S_FIN);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (acc_smp && fill_in >= n_sat) state_in = S_RUN;
         S_RUN:   if (k_in == n_sat) state_in = S_DRAIN;
         S_DRAIN: if (drain_ff == 2'd2) state_in = S_FIN;
         S_FIN:   state_in = S_OUT;
         S_OUT:   if (rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; fill_ff <= '0; k_ff <= '0; drain_ff <= '0;
         pos_ff <= '0; rpos_ff <= '0; rdone_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (acc_smp) begin
            fill_ff <= fill_in; k_ff <= '0;
         end else if (state_ff == S_RUN) k_ff <= k_in;
         drain_ff <= (state_ff == S_DRAIN) ? drain_ff + 2'd1 : 2'd0;
         if (state_ff == S_FIN) begin
            rpos_ff <= pos_ff; rdone_ff <= done;
            if (done) begin
               pos_ff <= '0; fill_ff <= '0;
            end else pos_ff <= pos_ff + 12'd1;
         end
      end
   end
endmodule

/* rtl/matched_filter_peak_index.sv */
// ----------------------------------------------------------------------------
// matched_filter_peak_index
// frame sync correlator with first-maximum peak index report
// ----------------------------------------------------------------------------
// tap loads and window-filling samples start no correlation and keep the block ready
// a correlating sample starts the single multiply accumulate walking the tap and window memories
// over n products, n being the clamped tap count; the next item is accepted only after
// its result has been transferred
// result is held in an output register until transferred
// synchronous active-high reset clears counters and argmax; memories are not cleared
module matched_filter_peak_index #(
   parameter int MAX_TAPS    = 256,
   parameter int MAX_OUTPUTS = 4096
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_op,
   input  logic [7:0]         req_tap_index,
   input  logic signed [15:0] req_tap_value,
   input  logic signed [15:0] req_sample,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_corr_value,
   output logic [11:0]        rsp_position,
   output logic               rsp_done_res,
   output logic [11:0]        rsp_sync_index,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [12:0]        csr_wdata
);
   import mfpi_pkg::*;

   localparam int AW = $clog2(MAX_TAPS);

   // configuration registers, reset to the full sizes
   logic [TAPS_W-1:0] num_taps_ff;
   logic [OUTS_W-1:0] num_outputs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_taps_ff    <= 9'd256;
         num_outputs_ff <= 13'd4096;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_NUM_TAPS:    num_taps_ff    <= csr_wdata[TAPS_W-1:0];
            CSR_NUM_OUTPUTS: num_outputs_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   mfpi_cmd_type  cmd;
   logic [AW-1:0] rd_k;
   logic [AW:0]   n_taps;
   logic [11:0]   position;
   logic          done;

   // sequencer
   mfpi_ctrl #(.MAX_TAPS(MAX_TAPS), .MAX_OUTPUTS(MAX_OUTPUTS), .AW(AW)) u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_op, .rsp_ready, .rsp_valid,
      .num_taps(num_taps_ff), .num_outputs(num_outputs_ff), .cmd, .rd_k, .n_taps,
      .position, .done, .rsp_position, .rsp_done(rsp_done_res)
   );

   // memories and multiply accumulate
   mfpi_datapath #(.MAX_TAPS(MAX_TAPS), .AW(AW)) u_dp (
      .clock, .reset, .cmd, .tap_index(req_tap_index), .tap_value(req_tap_value),
      .sample(req_sample), .rd_k, .n_taps, .position, .done,
      .corr_value(rsp_corr_value), .sync_index(rsp_sync_index)
   );
endmodule

/* bench/matched_filter_peak_index_tb.sv */
// ----------------------------------------------------------------------------
// matched_filter_peak_index_tb
// self-checking bench for the frame sync correlator: loads the template, streams
// samples through directed and random frames under random idling on both sides,
// and checks every correlation, position, done flag and sync index against its
// own bit-accurate prediction
// ----------------------------------------------------------------------------
module matched_filter_peak_index_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import mfpi_pkg::*;

   localparam int MAX_TAPS    = 256;
   localparam int MAX_OUTPUTS = 4096;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int DRAIN_WAIT  = MAX_TAPS + 40;   // one full-length correlation and margin

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic               req_op;
   logic [7:0]         req_tap_index;
   logic signed [15:0] req_tap_value;
   logic signed [15:0] req_sample;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [15:0] rsp_corr_value;
   logic [11:0]        rsp_position;
   logic               rsp_done_res;
   logic [11:0]        rsp_sync_index;
   logic               csr_we;
   logic               csr_index;
   logic [12:0]        csr_wdata;

   matched_filter_peak_index #(
      .MAX_TAPS   (MAX_TAPS),
      .MAX_OUTPUTS(MAX_OUTPUTS)
   ) uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_op        (req_op),
      .req_tap_index (req_tap_index),
      .req_tap_value (req_tap_value),
      .req_sample    (req_sample),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_corr_value(rsp_corr_value),
      .rsp_position  (rsp_position),
      .rsp_done_res  (rsp_done_res),
      .rsp_sync_index(rsp_sync_index),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   // one expected correlation result
   typedef struct {
      logic signed [15:0] corr;
      logic [11:0]        pos;
      logic               done;
      logic [11:0]        sync;
   } corr_result_type;

   corr_result_type corr_expected[$];

   // predictor state
   logic signed [15:0] tmpl_taps  [MAX_TAPS];
   logic signed [15:0] smp_window [MAX_TAPS];   // entry 0 is the newest sample
   int                 fill_cnt;
   int                 frame_pos;
   logic signed [15:0] peak_value;
   int                 peak_pos;
   logic [8:0]         cfg_taps;
   logic [12:0]        cfg_outputs;

   int  error_count;
   int  cycle_count;
   bit  no_idle;      // burst stretch: neither side idles

   // ---------------------------------------------------------------- clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // run watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------- prediction
   function automatic int clamp_range(int v, int lo, int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic void predict_correlation(logic op, logic [7:0] idx,
                                               logic signed [15:0] tval,
                                               logic signed [15:0] smp);
      int           n;
      int           nout;
      logic [31:0]  acc;
      logic signed [15:0] corr;
      corr_result_type r;
      if (op == OP_TAP) begin
         tmpl_taps[idx] = tval;   // 8-bit index always lands inside the table
         return;
      end
      for (int k = MAX_TAPS - 1; k > 0; k--) smp_window[k] = smp_window[k-1];
      smp_window[0] = smp;
      if (fill_cnt < MAX_TAPS) fill_cnt++;
      n = clamp_range(int'(cfg_taps), 4, MAX_TAPS);
      if (fill_cnt < n) return;   // window still filling
      acc = '0;
      // oldest sample in the window pairs with tap 0
      for (int k = 0; k < n; k++)
         acc = acc + 32'(int'(smp_window[k]) * int'(tmpl_taps[n-1-k]));
      corr = acc[30:15];
      // first strict maximum, position 0 always seeds it
      if (frame_pos == 0 || corr > peak_value) begin
         peak_value = corr;
         peak_pos   = frame_pos;
      end
      nout   = clamp_range(int'(cfg_outputs), 1, MAX_OUTPUTS);
      r.corr = corr;
      r.pos  = 12'(frame_pos);
      r.done = (frame_pos + 1 >= nout);
      r.sync = r.done ? 12'(peak_pos) : 12'd0;
      corr_expected.push_back(r);
      if (r.done) begin
         fill_cnt   = 0;
         frame_pos  = 0;
         peak_value = '0;
         peak_pos   = 0;
      end else begin
         frame_pos++;
      end
   endfunction

   // ---------------------------------------------------------------- checking
   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      error_count++;
   endtask

   // result side: random stalls, check every transfer against the oldest expectation
   initial begin
      int              stall;
      corr_result_type e;
      corr_result_type g;
      logic            seen;
      @(negedge reset);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 11);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         // sample mid-cycle so the values seen are those at the transfer edge
         forever begin
            @(negedge clock);
            seen   = rsp_valid;
            g.corr = rsp_corr_value;
            g.pos  = rsp_position;
            g.done = rsp_done_res;
            g.sync = rsp_sync_index;
            @(posedge clock);
            if (seen) break;
         end
         if (corr_expected.size() == 0) begin
            report_mismatch("unexpected result transfer at position", g.pos, -1);
         end else begin
            e = corr_expected.pop_front();
            if (g.corr !== e.corr)
               report_mismatch("corr_value", g.corr, e.corr);
            if (g.pos !== e.pos)
               report_mismatch("position", g.pos, e.pos);
            if (g.done !== e.done)
               report_mismatch("done_res", g.done, e.done);
            if (g.sync !== e.sync)
               report_mismatch("sync_index", g.sync, e.sync);
         end
      end
   end

   // ---------------------------------------------------------------- driving
   // sends one item; valid stays high across back-to-back transfers
   task automatic send_item(logic op, logic [7:0] idx, logic signed [15:0] tval,
                            logic signed [15:0] smp);
      int   gap;
      logic rdy;
      gap = no_idle ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_op        <= op;
      req_tap_index <= idx;
      req_tap_value <= tval;
      req_sample    <= smp;
      // ready sampled mid-cycle, the transfer happens at the following edge
      forever begin
         @(negedge clock);
         rdy = req_ready;
         @(posedge clock);
         if (rdy) break;
      end
      predict_correlation(op, idx, tval, smp);
   endtask

   task automatic send_sample(logic signed [15:0] smp);
      send_item(OP_SAMPLE, 8'($urandom), 16'($urandom), smp);
   endtask

   // waits out every pending result plus one full correlation time
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (corr_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [12:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      if (idx == CSR_NUM_TAPS) cfg_taps = data[8:0];
      else cfg_outputs = data;
   endtask

   task automatic set_frame(logic [12:0] taps, logic [12:0] outs);
      wait_idle();
      write_csr(CSR_NUM_TAPS, taps);
      write_csr(CSR_NUM_OUTPUTS, outs);
      csr_we <= 1'b0;
   endtask

   // ---------------------------------------------------------------- tests
   // every tap written so no read ever touches an unwritten entry
   task automatic test_tap_load_all();
      logic signed [15:0] v;
      for (int i = 0; i < MAX_TAPS; i++) begin
         if (i < 4) v = 16'sh8000;
         else if (i < 8) v = 16'sh7fff;
         else v = 16'($urandom);
         send_item(OP_TAP, 8'(i), v, 16'($urandom));
      end
   endtask

   // four products of the most negative values wrap the 32-bit sum to zero; then full scale positives
   task automatic test_wrap_and_extremes();
      set_frame(13'd4, 13'd1);
      repeat (4) send_sample(16'sh8000);
      repeat (4) send_sample(16'sh7fff);
      repeat (2) send_sample(16'sh8000);
      repeat (2) send_sample(16'sh7fff);
   endtask

   // equal correlations must keep the first position as the peak
   task automatic test_argmax_ties();
      set_frame(13'd4, 13'd5);
      repeat (8) send_sample(16'sd0);
      // rising ramp against the negative taps gives falling correlations: the peak stays at position 0
      for (int i = 0; i < 8; i++) send_sample(16'(i * 1000 - 4000));
   endtask

   // register changes between transfers while a frame is in progress
   task automatic test_midframe_changes();
      set_frame(13'd4, 13'd8);
      repeat (6) send_sample(16'($urandom));
      // frame already past the new count: next correlation ends it
      set_frame(13'd4, 13'd2);
      send_sample(16'($urandom));
      // window grows beyond the held samples: the next sample fills it
      set_frame(13'd4, 13'd8);
      repeat (5) send_sample(16'($urandom));
      set_frame(13'd6, 13'd8);
      repeat (3) send_sample(16'($urandom));
      // tap load in the middle of the stream
      send_item(OP_TAP, 8'd2, 16'($urandom), 16'($urandom));
      repeat (2) send_sample(16'($urandom));
   endtask

   // out-of-range and full-width register values
   task automatic test_register_extremes();
      set_frame(13'd0, 13'd0);                  // both saturate low
      repeat (6) send_sample(16'($urandom));
      set_frame(13'h1ff, 13'd2);                // taps saturate to maximum
      repeat (MAX_TAPS + 2) send_item(OP_SAMPLE, 8'($urandom), 16'($urandom),
                                      16'($urandom));
      set_frame(13'd256, 13'h1fff);             // outputs saturate to maximum
      repeat (4) send_sample(16'($urandom));
      set_frame(13'd5, 13'h1fff);
      repeat (8) send_sample(16'($urandom));
   endtask

   task automatic test_random_frames();
      int          items;
      logic [12:0] taps;
      logic [12:0] outs;
      for (int p = 0; p < 2; p++) begin
         taps  = 13'($urandom_range(4, 16));
         outs  = 13'($urandom_range(1, 9));
         items = 25;
         if ($urandom_range(0, 5) == 0) taps = 13'($urandom_range(0, 511));
         if ($urandom_range(0, 6) == 0) outs = 13'($urandom);
         if (taps > 40) items = 12;
         set_frame(taps, outs);
         no_idle = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < items; i++) begin
            if ($urandom_range(0, 6) == 0)
               send_item(OP_TAP, 8'($urandom), 16'($urandom), 16'($urandom));
            else
               send_sample(16'($urandom));
         end
         no_idle = 1'b0;
      end
   endtask

   // ---------------------------------------------------------------- sequence
   initial begin
      req_valid     <= 1'b0;
      req_op        <= OP_TAP;
      req_tap_index <= '0;
      req_tap_value <= '0;
      req_sample    <= '0;
      rsp_ready     <= 1'b0;
      csr_we        <= 1'b0;
      csr_index     <= CSR_NUM_TAPS;
      csr_wdata     <= '0;
      reset         <= 1'b1;
      error_count  = 0;
      no_idle      = 1'b0;
      fill_cnt     = 0;
      frame_pos    = 0;
      peak_value   = '0;
      peak_pos     = 0;
      cfg_taps     = 9'd256;
      cfg_outputs  = 13'd4096;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_tap_load_all();
      test_wrap_and_extremes();
      test_argmax_ties();
      test_midframe_changes();
      test_register_extremes();
      test_random_frames();

      wait_idle();
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
